[design/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[design/nrc_pkg.sv]
// shared types, widths and register codes of the 3x3 neighbour range clamp
// no dependencies
`default_nettype none
package nrc_pkg;
   localparam int PIXEL_W            = 8;
   localparam int FRAME_WIDTH_W      = 12;
   localparam int FRAME_HEIGHT_W     = 13;
   localparam int CSR_DATA_W         = 13;
   localparam int CSR_INDEX_W        = 1;
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 4096;
   localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 13'd480;
   localparam int QUEUE_DEPTH   = 8;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type [2:0][2:0] pix;
      logic                 top;
      logic                 bottom;
      logic                 left;
      logic                 right;
      logic                 last;
   } window_type;

   typedef struct packed {
      pixel_type lo;
      pixel_type hi;
      pixel_type centre;
      logic      last;
   } range_type;
endpackage
`default_nettype wire

[design/nrc_front.sv]
// front end: transfer acceptance, raster counters, line store and 3x3 window
// depends on nrc_pkg
`default_nettype none
module nrc_front #(
   parameter int MAX_WIDTH  = nrc_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = nrc_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [nrc_pkg::PIXEL_W-1:0]      req_pixel_in,
   input  logic                             room,
   input  logic                             csr_wr_en,
   input  logic [nrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nrc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             win_valid,
   output nrc_pkg::window_type              win,
   output logic [1:0]                       inflight
);
   import nrc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WC    = $clog2(MAX_WIDTH + 1);
   localparam int WX    = (WC > FRAME_WIDTH_W) ? WC : FRAME_WIDTH_W;
   localparam int ORW   = $clog2(MAX_HEIGHT);
   localparam int RC    = $clog2(MAX_HEIGHT + 2);
   localparam int HX    = (RC > FRAME_HEIGHT_W) ? RC : FRAME_HEIGHT_W;

   logic [FRAME_WIDTH_W-1:0]  cfg_width_ff;
   logic [FRAME_HEIGHT_W-1:0] cfg_height_ff;
   logic [WX-1:0]             width_ext;
   logic [HX-1:0]             height_ext;
   logic [WC-1:0]             used_w;
   logic [RC-1:0]             used_h;

   logic [COL_W-1:0] in_col_ff;
   logic [RC-1:0]    in_row_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ORW-1:0]   out_row_ff;

   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_ff;

   logic             s1_valid_ff;
   logic             s1_emit_ff;
   pixel_type        s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   window_type       win_ff;
   logic             win_valid_ff;

   logic      accept;
   logic      take;
   pixel_type pix_in;
   logic      col_wrap;
   logic      final_item;
   logic      emit;
   logic      has_top;
   logic      has_bottom;
   logic      has_left;
   logic      has_right;
   logic      out_last;

   // clamp the frame size registers into the supported range
   always_comb begin
      width_ext  = WX'(cfg_width_ff);
      height_ext = HX'(cfg_height_ff);
      if (width_ext < WX'(2)) begin
         used_w = WC'(2);
      end else if (width_ext > WX'(MAX_WIDTH)) begin
         used_w = WC'(MAX_WIDTH);
      end else begin
         used_w = WC'(width_ext);
      end
      if (height_ext < HX'(2)) begin
         used_h = RC'(2);
      end else if (height_ext > HX'(MAX_HEIGHT)) begin
         used_h = RC'(MAX_HEIGHT);
      end else begin
         used_h = RC'(height_ext);
      end
   end

   always_comb begin
      accept = req_valid && room;
      if (req_kind) begin
         take = accept && (in_row_ff >= used_h);
      end else begin
         take = accept && (in_row_ff < used_h);
      end
      pix_in     = req_kind ? '0 : req_pixel_in;
      col_wrap   = (WC'(in_col_ff) + WC'(1)) >= used_w;
      final_item = req_kind && (in_row_ff == (used_h + RC'(1)));
      emit       = (in_row_ff > RC'(1)) || ((in_row_ff == RC'(1)) && (in_col_ff != '0));
      has_top    = (out_row_ff != '0);
      has_bottom = (RC'(out_row_ff) + RC'(1)) < used_h;
      has_left   = (out_col_ff != '0);
      has_right  = (WC'(out_col_ff) + WC'(1)) < used_w;
      out_last   = !has_bottom && !has_right;
   end

   // counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RESET_FRAME_WIDTH;
         cfg_height_ff <= RESET_FRAME_HEIGHT;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         win_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= take;
         win_valid_ff <= s1_valid_ff && s1_emit_ff;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  cfg_width_ff <= csr_wdata[FRAME_WIDTH_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  cfg_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
               end
               default: begin
               end
            endcase
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (take) begin
               if (final_item) begin
                  in_col_ff <= '0;
                  in_row_ff <= '0;
               end else if (col_wrap) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + RC'(1);
               end else begin
                  in_col_ff <= in_col_ff + COL_W'(1);
               end
            end
            if (s1_valid_ff && s1_emit_ff) begin
               if (out_last) begin
                  out_col_ff <= '0;
                  out_row_ff <= '0;
               end else if (!has_right) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + ORW'(1);
               end else begin
                  out_col_ff <= out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   // line store: upper row in the high byte, middle row in the low byte
   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff <= line_mem[in_col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= {rd_ff[PIXEL_W-1:0], s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pix_ff  <= pix_in;
         s1_col_ff  <= in_col_ff;
         s1_emit_ff <= emit;
      end
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff.pix[r][0] <= win_ff.pix[r][1];
            win_ff.pix[r][1] <= win_ff.pix[r][2];
         end
         win_ff.pix[0][2] <= rd_ff[2*PIXEL_W-1:PIXEL_W];
         win_ff.pix[1][2] <= rd_ff[PIXEL_W-1:0];
         win_ff.pix[2][2] <= s1_pix_ff;
         win_ff.top       <= has_top;
         win_ff.bottom    <= has_bottom;
         win_ff.left      <= has_left;
         win_ff.right     <= has_right;
         win_ff.last      <= out_last;
      end
   end

   assign req_ready = room;
   assign win_valid = win_valid_ff;
   assign win       = win_ff;
   assign inflight  = {1'b0, s1_valid_ff} + {1'b0, win_valid_ff};
endmodule
`default_nettype wire

[design/nrc_minmax.sv]
// neighbour min/max stage: masked 8-input minimum and maximum trees
// depends on nrc_pkg
`default_nettype none
module nrc_minmax (
   input  logic                clock,
   input  logic                reset,
   input  logic                win_valid,
   input  nrc_pkg::window_type win,
   output logic                mm_valid,
   output nrc_pkg::range_type  mm_item
);
   import nrc_pkg::*;

   pixel_type lo_leaf [8];
   pixel_type hi_leaf [8];
   pixel_type lo_l1 [4];
   pixel_type hi_l1 [4];
   pixel_type lo_l2 [2];
   pixel_type hi_l2 [2];
   pixel_type lo_min;
   pixel_type hi_max;
   logic      mm_valid_ff;
   range_type mm_item_ff;

   always_comb begin
      int  n;
      logic en;
      n = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1)) begin
               en = (r != 0 || win.top) && (r != 2 || win.bottom) &&
                    (c != 0 || win.left) && (c != 2 || win.right);
               lo_leaf[n] = en ? win.pix[r][c] : '1;
               hi_leaf[n] = en ? win.pix[r][c] : '0;
               n = n + 1;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         lo_l1[i] = (lo_leaf[2*i] < lo_leaf[2*i+1]) ? lo_leaf[2*i] : lo_leaf[2*i+1];
         hi_l1[i] = (hi_leaf[2*i] > hi_leaf[2*i+1]) ? hi_leaf[2*i] : hi_leaf[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         lo_l2[i] = (lo_l1[2*i] < lo_l1[2*i+1]) ? lo_l1[2*i] : lo_l1[2*i+1];
         hi_l2[i] = (hi_l1[2*i] > hi_l1[2*i+1]) ? hi_l1[2*i] : hi_l1[2*i+1];
      end
      lo_min = (lo_l2[0] < lo_l2[1]) ? lo_l2[0] : lo_l2[1];
      hi_max = (hi_l2[0] > hi_l2[1]) ? hi_l2[0] : hi_l2[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_valid_ff <= 1'b0;
      end else begin
         mm_valid_ff <= win_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (win_valid) begin
         mm_item_ff.lo     <= lo_min;
         mm_item_ff.hi     <= hi_max;
         mm_item_ff.centre <= win.pix[1][1];
         mm_item_ff.last   <= win.last;
      end
   end

   assign mm_valid = mm_valid_ff;
   assign mm_item  = mm_item_ff;
endmodule
`default_nettype wire

[design/nrc_queue.sv]
// short queue between the min/max stage and the clamp/output stage
// depends on nrc_pkg
`default_nettype none
module nrc_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  nrc_pkg::range_type                  push_item,
   input  logic                                pop,
   output logic                                q_valid,
   output nrc_pkg::range_type                  q_item,
   output logic [nrc_pkg::QUEUE_COUNT_W-1:0]   count
);
   import nrc_pkg::*;

   range_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QUEUE_COUNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QUEUE_COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];
   assign count   = count_ff;
endmodule
`default_nettype wire

[design/nrc_back.sv]
// back end: clamp of the centre pixel and the registered result port
// depends on nrc_pkg
`default_nettype none
module nrc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  nrc_pkg::range_type           q_item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nrc_pkg::PIXEL_W-1:0]  rsp_pixel_out,
   output logic                         rsp_frame_last
);
   import nrc_pkg::*;

   logic      rsp_valid_ff;
   pixel_type rsp_pixel_ff;
   logic      rsp_last_ff;
   pixel_type clamped;

   always_comb begin
      if (q_item.centre > q_item.hi) begin
         clamped = q_item.hi;
      end else if (q_item.centre < q_item.lo) begin
         clamped = q_item.lo;
      end else begin
         clamped = q_item.centre;
      end
      pop = q_valid && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_pixel_ff <= clamped;
         rsp_last_ff  <= q_item.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;
endmodule
`default_nettype wire

[design/neighbour_range_clamp_3x3_core.sv]
// 3x3 neighbour range clamp, top level; depends on nrc_pkg and the nrc_* modules
// throughput: one transfer per cycle while the queue has room
// the line store has one read and one write port;
// each output lags its input by frame_width+1 raster positions
// reset: counters cleared, frame size 640x480, line store not cleared (no clearing pass)
`default_nettype none
`include "assert_macros.svh"
module neighbour_range_clamp_3x3_core #(
   parameter int MAX_WIDTH  = nrc_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = nrc_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [nrc_pkg::PIXEL_W-1:0]      req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nrc_pkg::PIXEL_W-1:0]      rsp_pixel_out,
   output logic                             rsp_frame_last,
   input  logic                             csr_wr_en,
   input  logic [nrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nrc_pkg::*;

   localparam logic [QUEUE_COUNT_W-1:0] QUEUE_FULL = QUEUE_COUNT_W'(QUEUE_DEPTH);

   logic                     room;
   logic                     win_valid;
   window_type               win;
   logic [1:0]               inflight;
   logic                     mm_valid;
   range_type                mm_item;
   logic                     fifo_pop;
   logic                     fifo_valid;
   range_type                fifo_item;
   logic [QUEUE_COUNT_W-1:0] fifo_count;
   logic [QUEUE_COUNT_W:0]   occupancy;

   // reserve a queue slot for every item still in the front end or min/max stage
   always_comb begin
      occupancy = (QUEUE_COUNT_W + 1)'(fifo_count) + (QUEUE_COUNT_W + 1)'(inflight) +
                  (QUEUE_COUNT_W + 1)'(mm_valid);
      room      = occupancy < (QUEUE_COUNT_W + 1)'(QUEUE_DEPTH);
   end

   nrc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_pixel_in (req_pixel_in),
      .room         (room),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .win_valid    (win_valid),
      .win          (win),
      .inflight     (inflight)
   );

   nrc_minmax u_minmax (
      .clock     (clock),
      .reset     (reset),
      .win_valid (win_valid),
      .win       (win),
      .mm_valid  (mm_valid),
      .mm_item   (mm_item)
   );

   nrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mm_valid),
      .push_item (mm_item),
      .pop       (fifo_pop),
      .q_valid   (fifo_valid),
      .q_item    (fifo_item),
      .count     (fifo_count)
   );

   nrc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (fifo_valid),
      .q_item         (fifo_item),
      .pop            (fifo_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

   `ASSERT_IMPLIES(a_queue_no_overflow, clock, reset, mm_valid, fifo_count != QUEUE_FULL)
   `ASSERT_IMPLIES(a_pop_not_empty, clock, reset, fifo_pop, fifo_count != '0)
   `ASSERT_NEXT(a_push_lands, clock, reset, mm_valid, fifo_count != '0)
endmodule
`default_nettype wire
